// File: design/dsid_pkg.sv
// Package for the date span block: date types, calendar tables and helper functions.
package dsid_pkg;

  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned ShYearW = YearW + 1;   // year + 400, March-based
  localparam int unsigned DnumW   = 23;          // day number width
  localparam int unsigned CountW  = 22;
  localparam int unsigned CentW   = 8;           // year / 100
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [12:0]       Recip25  = 13'd5243;   // ceil(2^17 / 25)

  // Per-date values registered after the first stage
  typedef struct packed {
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
    logic [ShYearW-1:0] yy;        // shifted year, Jan/Feb belong to the prior year
    logic [CentW-1:0]   yy_cent;   // yy / 100
    logic [CentW-1:0]   y_cent;    // year / 100, for the leap rule
  } date_s1_t;

  // floor(x / 25) for x below 4200, by reciprocal multiply
  function automatic logic [CentW-1:0] div25(input logic [12:0] x);
    logic [25:0] prod;
    begin
      prod = 26'(x) * 26'(Recip25);
      return prod[24:17];
    end
  endfunction

  // Days from March 1 to the first of the month
  function automatic logic [8:0] doy_base(input logic [MonthW-1:0] m);
    begin
      case (m)
        4'd3:    return 9'd0;
        4'd4:    return 9'd31;
        4'd5:    return 9'd61;
        4'd6:    return 9'd92;
        4'd7:    return 9'd122;
        4'd8:    return 9'd153;
        4'd9:    return 9'd184;
        4'd10:   return 9'd214;
        4'd11:   return 9'd245;
        4'd12:   return 9'd275;
        4'd1:    return 9'd306;
        4'd2:    return 9'd337;
        default: return 9'd0;
      endcase
    end
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
    begin
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                     return 5'd30;
        4'd2:    return leap ? 5'd29 : 5'd28;
        default: return 5'd0;
      endcase
    end
  endfunction

  function automatic date_s1_t prep_date(input logic [DayW-1:0] d,
                                         input logic [MonthW-1:0] m,
                                         input logic [YearW-1:0] y);
    date_s1_t s;
    begin
      s.day     = d;
      s.month   = m;
      s.year    = y;
      s.yy      = ShYearW'(y) + ShYearW'(400) - ((m <= 4'd2) ? ShYearW'(1) : ShYearW'(0));
      s.yy_cent = div25(s.yy[ShYearW-1:2]);
      s.y_cent  = div25(13'(y[YearW-1:2]));
      return s;
    end
  endfunction

  function automatic logic date_ok(input date_s1_t s);
    logic [11:0] q4;
    logic        cent;
    logic        leap;
    begin
      q4   = s.year[YearW-1:2];
      // year % 100 == 0 when year % 4 == 0 and (year / 4) % 25 == 0
      cent = (s.year[1:0] == 2'd0) && (q4 == 12'(s.y_cent) * 12'd25);
      leap = (s.year[1:0] == 2'd0) && (!cent || (s.y_cent[1:0] == 2'd0));
      return (s.day != '0) && (s.month >= 4'd1) && (s.month <= 4'd12) &&
             (s.day <= month_len(s.month, leap));
    end
  endfunction

  function automatic logic [DnumW-1:0] day_num(input date_s1_t s);
    logic [23:0] base;
    begin
      base = 24'(s.yy) * 24'(365);
      return base[DnumW-1:0] + DnumW'(s.yy >> 2) - DnumW'(s.yy_cent)
           + DnumW'(s.yy_cent >> 2) + DnumW'(doy_base(s.month))
           + DnumW'(s.day) - DnumW'(1);
    end
  endfunction

endpackage

// File: design/date_span_in_days_top.sv
// Date span: days between two Gregorian dates, three-stage pipeline.
//
// Input transfer (in_tdata) carries a start date, an end date and the
// include-end flag. Each input transfer yields one output transfer with the
// day count from start to end (zero when start is not before end), plus one
// when include-end is set, and a flag for an impossible date (count then 0).
// Day numbers are formed in closed form: two reciprocal multiplies per date give
// the century quotients, a constant multiply by 365 and an adder row give the day
// number, and a subtract with clamp gives the count.
// An input transfer passes the stage 1, stage 2 and output registers to out_tvalid.
// Throughput: one item per cycle while out_tready stays high; each stage holds
// one item and moves on whenever the stage after it is empty or moving.
// When the receiver holds out_tready low the stages fill up, then in_tready
// drops; nothing is lost or repeated. Reset empties all stages.
module date_span_in_days_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // start_day[4:0], start_month[8:5], start_year[22:9], end_day[27:23],
  // end_month[31:28], end_year[45:32], include_end[46], zero [47]
  input  logic [dsid_pkg::InDataW-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // day_count[21:0], invalid_date[22], zero [23]
  output logic [dsid_pkg::OutDataW-1:0]  out_tdata
);
  import dsid_pkg::*;

  logic                 adv2, adv3;
  logic                 v1_r, v2_r, ov_r;
  date_s1_t             s1a_r, s1b_r;
  logic                 inc1_r, inc2_r;
  logic                 ok2_r;
  logic [DnumW-1:0]     dna_r, dnb_r;
  logic [CountW-1:0]    count_r;
  logic                 bad_r;
  logic [DnumW-1:0]     span;
  logic [DnumW-1:0]     span_inc;
  logic [CountW-1:0]    count_nxt;

  assign adv3      = !ov_r || out_tready;
  assign adv2      = !v2_r || adv3;
  assign in_tready = !v1_r || adv2;

  // Stage 1: field split, shifted year and century quotients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1a_r  <= prep_date(in_tdata[4:0], in_tdata[8:5], in_tdata[22:9]);
      s1b_r  <= prep_date(in_tdata[27:23], in_tdata[31:28], in_tdata[45:32]);
      inc1_r <= in_tdata[46];
    end
  end

  // Stage 2: validity check and day numbers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
    if (adv2 && v1_r) begin
      ok2_r  <= date_ok(s1a_r) && date_ok(s1b_r);
      dna_r  <= day_num(s1a_r);
      dnb_r  <= day_num(s1b_r);
      inc2_r <= inc1_r;
    end
  end

  // Stage 3: span, include-end, clamp, zero count for an invalid date
  always_comb begin
    span      = (dna_r < dnb_r) ? (dnb_r - dna_r) : '0;
    span_inc  = span + DnumW'(inc2_r);
    count_nxt = (span_inc > DnumW'(CountMax)) ? CountMax : span_inc[CountW-1:0];
    if (!ok2_r) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv3) begin
      ov_r <= v2_r;
    end
    if (adv3 && v2_r) begin
      count_r <= count_nxt;
      bad_r   <= !ok2_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, bad_r, count_r};

`ifndef SYNTH
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && bad_r |-> count_r == '0)
    else $error("invalid date with nonzero count");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && ov_r && !out_tready |-> !in_tready)
    else $error("input taken while pipeline full and stalled");

  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && adv3 |=> ov_r)
    else $error("item lost between stage 2 and output");
`endif

endmodule
